// ===== rtl/core/flsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package flsm_pkg;

  localparam int SLOTS      = 4;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int KIND_W     = 3;
  localparam int SEQ_W      = 32;
  localparam int LEASE_W    = 32;
  localparam int STAT_W     = 32;
  localparam int DISC_W     = 3;
  localparam int OUT_SLOT_W = 2;
  localparam int SST_W      = 3;

  localparam logic [DISC_W-1:0] DISC_MAX = '1;

  typedef enum logic [1:0] {
    ST_FREE      = 2'd0,
    ST_CAPTURING = 2'd1,
    ST_READY     = 2'd2,
    ST_LEASED    = 2'd3
  } slot_state_t;

  typedef enum logic [KIND_W-1:0] {
    EV_FRAME_START  = 3'd0,
    EV_FRAME_FINISH = 3'd1,
    EV_ACQUIRE      = 3'd2,
    EV_RELEASE      = 3'd3,
    EV_PAUSE        = 3'd4,
    EV_RESUME       = 3'd5,
    EV_START        = 3'd6,
    EV_STOP         = 3'd7
  } event_kind_t;

  typedef enum logic [SST_W-1:0] {
    SS_STOPPED   = 3'd0,
    SS_PAUSED    = 3'd1,
    SS_CAPTURING = 3'd2,
    SS_SYNCING   = 3'd3,
    SS_WAITING   = 3'd4
  } stream_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic apply;
  } flsm_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } flsm_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/flsm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface flsm_in_if
  import flsm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [LEASE_W-1:0]  release_lease;
  logic [STAT_W-1:0]   hw_status;

  modport source (output valid, output kind, output release_lease, output hw_status,
                  input ready);
  modport sink (input valid, input kind, input release_lease, input hw_status,
                output ready);
endinterface

interface flsm_out_if
  import flsm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [OUT_SLOT_W-1:0] slot;
  logic [SEQ_W-1:0]      frame_sequence;
  logic [LEASE_W-1:0]    granted_lease;
  logic [DISC_W-1:0]     ready_discarded;
  logic                  busy_drop;
  logic                  frame_held;
  logic [SST_W-1:0]      stream_state;
  logic [STAT_W-1:0]     status_word;

  modport source (output valid, output ok, output slot, output frame_sequence,
                  output granted_lease, output ready_discarded, output busy_drop,
                  output frame_held, output stream_state, output status_word,
                  input ready);
  modport sink (input valid, input ok, input slot, input frame_sequence,
                input granted_lease, input ready_discarded, input busy_drop,
                input frame_held, input stream_state, input status_word,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/flsm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module flsm_ctrl
  import flsm_pkg::*;
(
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  wire flsm_sts_t sts,
  output flsm_cmd_t      cmd
);

  typedef enum logic [1:0] {
    C_IDLE,
    C_SCAN,
    C_WAIT
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    in_ready  = (state_r == C_IDLE);
    cmd.load  = in_valid && in_ready;
    cmd.step  = (state_r == C_SCAN);
    cmd.apply = (state_r == C_WAIT) && sts.out_free;
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE: begin
        if (cmd.load) state_nxt = C_SCAN;
      end
      C_SCAN: begin
        if (sts.scan_last) state_nxt = C_WAIT;
      end
      C_WAIT: begin
        if (sts.out_free) state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_scan_length: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> ##(SLOTS + 1) (state_r == C_WAIT))
    else $error("Scan did not end after one pass over the slots.");

  a_blocked_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> ##(SLOTS + 1) !in_ready)
    else $error("A new transfer was possible before the event was applied.");

endmodule

`default_nettype wire

// ===== rtl/core/flsm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module flsm_datapath
  import flsm_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire flsm_cmd_t             cmd,
  output flsm_sts_t                  sts,
  input  wire logic [KIND_W-1:0]     in_kind,
  input  wire logic [LEASE_W-1:0]    in_release_lease,
  input  wire logic [STAT_W-1:0]     in_hw_status,
  input  wire                        out_ready,
  output logic                       out_valid,
  output logic                       out_ok,
  output logic [OUT_SLOT_W-1:0]      out_slot,
  output logic [SEQ_W-1:0]           out_frame_sequence,
  output logic [LEASE_W-1:0]         out_granted_lease,
  output logic [DISC_W-1:0]          out_ready_discarded,
  output logic                       out_busy_drop,
  output logic                       out_frame_held,
  output logic [SST_W-1:0]           out_stream_state,
  output logic [STAT_W-1:0]          out_status_word
);

  slot_state_t          status_r [SLOTS];
  slot_state_t          status_nxt [SLOTS];
  logic [SEQ_W-1:0]     seq_r [SLOTS];
  logic [SEQ_W-1:0]     seq_nxt [SLOTS];
  logic [LEASE_W-1:0]   owner_r [SLOTS];
  logic [LEASE_W-1:0]   owner_nxt [SLOTS];

  logic                 running_r, running_nxt;
  logic                 paused_r, paused_nxt;
  logic                 sync_r, sync_nxt;
  logic                 cap_act_r, cap_act_nxt;
  logic [SLOT_W-1:0]    cap_idx_r, cap_idx_nxt;
  logic [SEQ_W-1:0]     seq_cnt_r, seq_cnt_nxt;
  logic [LEASE_W-1:0]   lease_cnt_r, lease_cnt_nxt;
  logic [STAT_W-1:0]    last_r, last_nxt;

  event_kind_t          kind_r, kind_nxt;
  logic [LEASE_W-1:0]   rel_r, rel_nxt;
  logic [STAT_W-1:0]    hw_r, hw_nxt;
  logic [SLOT_W-1:0]    sidx_r, sidx_nxt;
  logic [SLOT_W-1:0]    pick_r, pick_nxt;
  logic                 pick_vld_r, pick_vld_nxt;
  logic                 free_found_r, free_found_nxt;
  logic                 hit_r, hit_nxt;
  logic                 capt_ok_r, capt_ok_nxt;
  logic [SEQ_W-1:0]     best_r, best_nxt;
  logic [CNT_W-1:0]     rdy_cnt_r, rdy_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 ok_r, ok_nxt;
  logic [OUT_SLOT_W-1:0] slot_r, slot_nxt;
  logic [SEQ_W-1:0]     fseq_r, fseq_nxt;
  logic [LEASE_W-1:0]   glease_r, glease_nxt;
  logic [DISC_W-1:0]    disc_r, disc_nxt;
  logic                 busy_r, busy_nxt;
  logic                 have_r, have_nxt;
  logic [SST_W-1:0]     sst_r, sst_nxt;

  slot_state_t          st_s;
  logic [SEQ_W-1:0]     sq_s;
  logic [LEASE_W-1:0]   ow_s;
  logic [SLOTS-1:0]     capt_vec;
  logic [SLOTS-1:0]     used_vec;

  assign st_s = status_r[sidx_r];
  assign sq_s = seq_r[sidx_r];
  assign ow_s = owner_r[sidx_r];

  assign sts = '{scan_last: (sidx_r == SLOT_W'(SLOTS - 1)),
                 out_free:  (!out_valid_r || out_ready)};

  always_comb begin
    logic                 r_ok;
    logic [SLOT_W-1:0]    r_slot;
    logic [SEQ_W-1:0]     r_fseq;
    logic [LEASE_W-1:0]   r_lease;
    logic [CNT_W-1:0]     r_disc;
    logic                 r_busy;
    logic                 r_have;
    logic [SEQ_W-1:0]     seq_inc;
    logic [LEASE_W-1:0]   lease_inc;
    logic [LEASE_W-1:0]   lease_new;
    stream_state_t        r_sst;

    status_nxt     = status_r;
    seq_nxt        = seq_r;
    owner_nxt      = owner_r;
    running_nxt    = running_r;
    paused_nxt     = paused_r;
    sync_nxt       = sync_r;
    cap_act_nxt    = cap_act_r;
    cap_idx_nxt    = cap_idx_r;
    seq_cnt_nxt    = seq_cnt_r;
    lease_cnt_nxt  = lease_cnt_r;
    last_nxt       = last_r;
    kind_nxt       = kind_r;
    rel_nxt        = rel_r;
    hw_nxt         = hw_r;
    sidx_nxt       = sidx_r;
    pick_nxt       = pick_r;
    pick_vld_nxt   = pick_vld_r;
    free_found_nxt = free_found_r;
    hit_nxt        = hit_r;
    capt_ok_nxt    = capt_ok_r;
    best_nxt       = best_r;
    rdy_cnt_nxt    = rdy_cnt_r;
    out_valid_nxt  = out_valid_r;
    ok_nxt         = ok_r;
    slot_nxt       = slot_r;
    fseq_nxt       = fseq_r;
    glease_nxt     = glease_r;
    disc_nxt       = disc_r;
    busy_nxt       = busy_r;
    have_nxt       = have_r;
    sst_nxt        = sst_r;

    r_ok      = 1'b0;
    r_slot    = '0;
    r_fseq    = '0;
    r_lease   = '0;
    r_disc    = '0;
    r_busy    = 1'b0;
    r_have    = 1'b0;
    r_sst     = SS_STOPPED;
    seq_inc   = seq_cnt_r + SEQ_W'(1);
    lease_inc = lease_cnt_r + LEASE_W'(1);
    lease_new = (lease_inc == '0) ? LEASE_W'(1) : lease_inc;

    if (cmd.load) begin
      kind_nxt       = event_kind_t'(in_kind);
      rel_nxt        = in_release_lease;
      hw_nxt         = in_hw_status;
      sidx_nxt       = '0;
      pick_nxt       = '0;
      pick_vld_nxt   = 1'b0;
      free_found_nxt = 1'b0;
      hit_nxt        = 1'b0;
      capt_ok_nxt    = 1'b0;
      best_nxt       = '0;
      rdy_cnt_nxt    = '0;
    end

    if (cmd.step) begin
      sidx_nxt = sidx_r + SLOT_W'(1);
      if (st_s == ST_READY) rdy_cnt_nxt = rdy_cnt_r + CNT_W'(1);
      if (sidx_r == cap_idx_r && st_s == ST_CAPTURING) capt_ok_nxt = 1'b1;
      priority if (kind_r == EV_FRAME_START) begin
        // The first free slot ends the search; otherwise the oldest ready frame wins.
        if (!free_found_r) begin
          if (st_s == ST_FREE) begin
            pick_nxt       = sidx_r;
            pick_vld_nxt   = 1'b1;
            free_found_nxt = 1'b1;
          end else if (st_s == ST_READY && (!pick_vld_r || sq_s < best_r)) begin
            pick_nxt     = sidx_r;
            pick_vld_nxt = 1'b1;
            best_nxt     = sq_s;
          end
        end
      end else if (kind_r == EV_ACQUIRE) begin
        if (st_s == ST_READY && (!pick_vld_r || sq_s > best_r)) begin
          pick_nxt     = sidx_r;
          pick_vld_nxt = 1'b1;
          best_nxt     = sq_s;
        end
      end else if (kind_r == EV_RELEASE) begin
        if (!hit_r && st_s == ST_LEASED && ow_s == rel_r) begin
          pick_nxt = sidx_r;
          hit_nxt  = 1'b1;
        end
      end else begin
      end
    end

    if (cmd.apply) begin
      unique case (kind_r)
        EV_FRAME_START: begin
          last_nxt = hw_r;
          if (running_r && !paused_r && !cap_act_r) begin
            if (sync_r) begin
              sync_nxt = 1'b0;
            end else if (!pick_vld_r) begin
              r_busy = 1'b1;
            end else begin
              if (!free_found_r) r_disc = CNT_W'(1);
              status_nxt[pick_r] = ST_CAPTURING;
              cap_act_nxt        = 1'b1;
              cap_idx_nxt        = pick_r;
              r_ok               = 1'b1;
              r_slot             = pick_r;
            end
          end
        end
        EV_FRAME_FINISH: begin
          last_nxt = hw_r;
          if (cap_act_r && capt_ok_r) begin
            seq_cnt_nxt           = seq_inc;
            seq_nxt[cap_idx_r]    = seq_inc;
            status_nxt[cap_idx_r] = ST_READY;
            r_ok                  = 1'b1;
            r_slot                = cap_idx_r;
            r_fseq                = seq_inc;
            cap_act_nxt           = 1'b0;
            cap_idx_nxt           = '0;
          end
        end
        EV_ACQUIRE: begin
          if (running_r && pick_vld_r) begin
            for (int j = 0; j < SLOTS; j++) begin
              if (status_r[j] == ST_READY && SLOT_W'(j) != pick_r) status_nxt[j] = ST_FREE;
            end
            r_disc             = rdy_cnt_r - CNT_W'(1);
            lease_cnt_nxt      = lease_new;
            owner_nxt[pick_r]  = lease_new;
            status_nxt[pick_r] = ST_LEASED;
            r_ok               = 1'b1;
            r_slot             = pick_r;
            r_fseq             = best_r;
            r_lease            = lease_new;
          end
        end
        EV_RELEASE: begin
          if (rel_r != '0 && running_r && hit_r) begin
            owner_nxt[pick_r]  = '0;
            status_nxt[pick_r] = ST_FREE;
            r_ok               = 1'b1;
          end
        end
        EV_PAUSE: begin
          if (running_r) paused_nxt = 1'b1;
        end
        EV_RESUME: begin
          if (running_r) begin
            for (int j = 0; j < SLOTS; j++) begin
              if (status_r[j] == ST_READY) status_nxt[j] = ST_FREE;
            end
            r_disc     = rdy_cnt_r;
            paused_nxt = 1'b0;
            sync_nxt   = 1'b1;
          end
        end
        EV_START: begin
          for (int j = 0; j < SLOTS; j++) begin
            status_nxt[j] = ST_FREE;
            owner_nxt[j]  = '0;
            seq_nxt[j]    = '0;
          end
          running_nxt   = 1'b1;
          paused_nxt    = 1'b0;
          sync_nxt      = 1'b1;
          cap_act_nxt   = 1'b0;
          cap_idx_nxt   = '0;
          seq_cnt_nxt   = '0;
          lease_cnt_nxt = '0;
          last_nxt      = hw_r;
          r_ok          = 1'b1;
        end
        EV_STOP: begin
          for (int j = 0; j < SLOTS; j++) begin
            status_nxt[j] = ST_FREE;
            owner_nxt[j]  = '0;
          end
          running_nxt = 1'b0;
          paused_nxt  = 1'b1;
          sync_nxt    = 1'b1;
          cap_act_nxt = 1'b0;
          cap_idx_nxt = '0;
        end
        default: begin
        end
      endcase

      for (int j = 0; j < SLOTS; j++) begin
        if (status_nxt[j] == ST_READY || status_nxt[j] == ST_LEASED) r_have = 1'b1;
      end
      r_have = r_have && running_nxt;

      priority if (!running_nxt) r_sst = SS_STOPPED;
      else if (paused_nxt)       r_sst = SS_PAUSED;
      else if (cap_act_nxt)      r_sst = SS_CAPTURING;
      else if (sync_nxt)         r_sst = SS_SYNCING;
      else                       r_sst = SS_WAITING;

      out_valid_nxt = 1'b1;
      ok_nxt        = r_ok;
      slot_nxt      = OUT_SLOT_W'(r_slot);
      fseq_nxt      = r_fseq;
      glease_nxt    = r_lease;
      disc_nxt      = (r_disc > CNT_W'(DISC_MAX)) ? DISC_MAX : DISC_W'(r_disc);
      busy_nxt      = r_busy;
      have_nxt      = r_have;
      sst_nxt       = r_sst;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < SLOTS; j++) begin
        status_r[j] <= ST_FREE;
        seq_r[j]    <= '0;
        owner_r[j]  <= '0;
      end
      running_r    <= 1'b0;
      paused_r     <= 1'b0;
      sync_r       <= 1'b0;
      cap_act_r    <= 1'b0;
      cap_idx_r    <= '0;
      seq_cnt_r    <= '0;
      lease_cnt_r  <= '0;
      last_r       <= '0;
      sidx_r       <= '0;
      pick_vld_r   <= 1'b0;
      free_found_r <= 1'b0;
      hit_r        <= 1'b0;
      capt_ok_r    <= 1'b0;
      rdy_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      status_r     <= status_nxt;
      seq_r        <= seq_nxt;
      owner_r      <= owner_nxt;
      running_r    <= running_nxt;
      paused_r     <= paused_nxt;
      sync_r       <= sync_nxt;
      cap_act_r    <= cap_act_nxt;
      cap_idx_r    <= cap_idx_nxt;
      seq_cnt_r    <= seq_cnt_nxt;
      lease_cnt_r  <= lease_cnt_nxt;
      last_r       <= last_nxt;
      sidx_r       <= sidx_nxt;
      pick_vld_r   <= pick_vld_nxt;
      free_found_r <= free_found_nxt;
      hit_r        <= hit_nxt;
      capt_ok_r    <= capt_ok_nxt;
      rdy_cnt_r    <= rdy_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    rel_r    <= rel_nxt;
    hw_r     <= hw_nxt;
    pick_r   <= pick_nxt;
    best_r   <= best_nxt;
    ok_r     <= ok_nxt;
    slot_r   <= slot_nxt;
    fseq_r   <= fseq_nxt;
    glease_r <= glease_nxt;
    disc_r   <= disc_nxt;
    busy_r   <= busy_nxt;
    have_r   <= have_nxt;
    sst_r    <= sst_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_ok              = ok_r;
  assign out_slot            = slot_r;
  assign out_frame_sequence  = fseq_r;
  assign out_granted_lease   = glease_r;
  assign out_ready_discarded = disc_r;
  assign out_busy_drop       = busy_r;
  assign out_frame_held      = have_r;
  assign out_stream_state    = sst_r;
  assign out_status_word     = last_r;

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      capt_vec[j] = (status_r[j] == ST_CAPTURING);
      used_vec[j] = (status_r[j] != ST_FREE);
    end
  end

  a_capture_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cap_act_r |-> (status_r[cap_idx_r] == ST_CAPTURING))
    else $error("Active capture does not point at a capturing slot.");

  a_single_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_act_r && $onehot(capt_vec)) || (!cap_act_r && capt_vec == '0))
    else $error("Capturing slots disagree with the capture flag.");

  a_stopped_free: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (used_vec == '0))
    else $error("A slot is in use while the stream is stopped.");

endmodule

`default_nettype wire

// ===== rtl/core/frame_slot_lease_manager_core.sv =====
// Channel  | Direction | Transfer when        | Payload
// in_ch    | input     | valid and ready high | kind, release_lease, hw_status
// out_ch   | output    | valid and ready high | ok, slot, frame_sequence, granted_lease,
//          |           |                      | ready_discarded, busy_drop, frame_held,
//          |           |                      | stream_state, status_word
//
// Each event goes through these steps in order: the input transfer is taken,
// every slot of the slot table is scanned, and the event is applied.
// The scan reads one slot per cycle.
// Reset is synchronous and active low; all slots come out free and the stream stopped.
// A result waits in the output register while the next event is taken and scanned;
// only the apply step stalls until that register has been emptied.
`timescale 1ns / 1ps
`default_nettype none

module frame_slot_lease_manager_core
  import flsm_pkg::*;
(
  input wire          clk,
  input wire          rst_n,
  flsm_in_if.sink     in_ch,
  flsm_out_if.source  out_ch
);

  flsm_cmd_t cmd;
  flsm_sts_t sts;

  flsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  flsm_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_kind             (in_ch.kind),
    .in_release_lease    (in_ch.release_lease),
    .in_hw_status        (in_ch.hw_status),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_ok              (out_ch.ok),
    .out_slot            (out_ch.slot),
    .out_frame_sequence  (out_ch.frame_sequence),
    .out_granted_lease   (out_ch.granted_lease),
    .out_ready_discarded (out_ch.ready_discarded),
    .out_busy_drop       (out_ch.busy_drop),
    .out_frame_held      (out_ch.frame_held),
    .out_stream_state    (out_ch.stream_state),
    .out_status_word     (out_ch.status_word)
  );

endmodule

`default_nettype wire
